// File: hw/rtl/round_robin_thread_scheduler_assert.svh
// Assertion macros for the round-robin thread scheduler.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// File: hw/rtl/rrts_pkg.sv
// Shared types and constants for the round-robin thread scheduler.
// No dependencies.
package rrts_pkg;

  localparam int NTHR  = 16;
  localparam int ID_W  = 4;
  localparam int CNT_W = 5;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_SLICE = 3'd0;

  // input modes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_CREATE  = 3'd1;
  localparam logic [2:0] MODE_START   = 3'd2;
  localparam logic [2:0] MODE_TERM    = 3'd3;
  localparam logic [2:0] MODE_DESTROY = 3'd4;

  // thread life states
  localparam logic [2:0] TS_FREE    = 3'd0;
  localparam logic [2:0] TS_CREATED = 3'd1;
  localparam logic [2:0] TS_FRESH   = 3'd2;
  localparam logic [2:0] TS_READY   = 3'd3;
  localparam logic [2:0] TS_RUNNING = 3'd4;
  localparam logic [2:0] TS_ENDED   = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOFREE   = 2'd1;
  localparam logic [1:0] STAT_BADID    = 2'd2;
  localparam logic [1:0] STAT_NOSWITCH = 2'd3;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] tid;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  new_id;
    logic [ID_W-1:0]  running_id;
    logic             switched;
    logic             fresh_start;
    logic [CNT_W-1:0] runnable_count;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DEC, OP_ROT, OP_SHIFT, OP_TAIL, OP_DROP,
    OP_HEAD, OP_INC, OP_CREATE, OP_START, OP_END, OP_FREE, OP_ERR
  } op_t;

  // which table entry the status read port looks at
  typedef enum logic [1:0] {TSEL_ID, TSEL_SCAN, TSEL_HEAD} tsel_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] err;
    tsel_t      tsel;
    logic       q_next;
  } ctl_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [2:0]       id_stat;
    logic [CNT_W-1:0] qcnt;
    logic             rot_go;
    logic             idx_last;
    logic             idx_end;
    logic             idx_zero;
    logic             q_hit;
    logic             more;
  } sts_t;

endpackage

// File: hw/rtl/rrts_ctrl.sv
// Sequencer for the thread scheduler: decodes each word and steps the datapath.
// Depends on rrts_pkg.
module rrts_ctrl import rrts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy,
  output logic done
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_ROT, S_SCAN, S_FIND, S_SHIFT, S_HEAD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   rot_r, rot_nxt;
  logic   head_r, head_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    rot_nxt   = rot_r;
    head_nxt  = head_r;
    ctl       = '{op: OP_NONE, err: STAT_OK, tsel: TSEL_ID, q_next: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        priority case (sts.mode)
          MODE_TICK: begin
            ctl.op = OP_DEC;
            if (sts.rot_go) state_nxt = S_ROT;
          end
          MODE_CREATE: state_nxt = S_SCAN;
          MODE_START: begin
            if (sts.id_stat == TS_CREATED && sts.qcnt < CNT_W'(NTHR)) begin
              ctl.op = OP_START;
            end else begin
              ctl.op  = OP_ERR;
              ctl.err = STAT_BADID;
            end
          end
          MODE_TERM: state_nxt = S_FIND;
          MODE_DESTROY: begin
            if (sts.id_stat == TS_FREE) begin
              ctl.op  = OP_ERR;
              ctl.err = STAT_BADID;
            end else if (sts.id_stat == TS_CREATED || sts.id_stat == TS_ENDED) begin
              ctl.op = OP_FREE;
            end else begin
              state_nxt = S_FIND;
            end
          end
          default: begin
            ctl.op  = OP_ERR;
            ctl.err = STAT_BADID;
          end
        endcase
      end
      S_ROT: begin
        ctl.op    = OP_ROT;
        rot_nxt   = 1'b1;
        state_nxt = S_SHIFT;
      end
      // rotating search for a free id
      S_SCAN: begin
        ctl.tsel = TSEL_SCAN;
        if (sts.id_stat == TS_FREE) begin
          ctl.op    = OP_CREATE;
          state_nxt = S_DONE;
        end else if (sts.idx_last) begin
          ctl.op    = OP_ERR;
          ctl.err   = STAT_NOFREE;
          state_nxt = S_DONE;
        end else begin
          ctl.op = OP_INC;
        end
      end
      // walk the run queue for the target id
      S_FIND: begin
        if (sts.idx_end) begin
          ctl.op    = OP_ERR;
          ctl.err   = STAT_BADID;
          state_nxt = S_DONE;
        end else if (sts.q_hit) begin
          if (sts.idx_zero && sts.qcnt < CNT_W'(2)) begin
            ctl.op    = OP_ERR;
            ctl.err   = STAT_NOSWITCH;
            state_nxt = S_DONE;
          end else begin
            ctl.op    = OP_END;
            rot_nxt   = 1'b0;
            head_nxt  = sts.idx_zero;
            state_nxt = S_SHIFT;
          end
        end else begin
          ctl.op = OP_INC;
        end
      end
      // close the gap one entry a cycle
      S_SHIFT: begin
        ctl.q_next = 1'b1;
        if (sts.more) begin
          ctl.op = OP_SHIFT;
        end else if (rot_r) begin
          ctl.op    = OP_TAIL;
          state_nxt = S_HEAD;
        end else begin
          ctl.op    = OP_DROP;
          state_nxt = head_r ? S_HEAD : S_DONE;
        end
      end
      S_HEAD: begin
        ctl.tsel  = TSEL_HEAD;
        ctl.op    = OP_HEAD;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rot_r   <= 1'b0;
      head_r  <= 1'b0;
      busy    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      head_r  <= head_nxt;
      busy    <= (state_nxt != S_IDLE);
      done    <= (state_nxt == S_DONE);
    end
  end

endmodule

// File: hw/rtl/rrts_dpath.sv
// Datapath of the thread scheduler: thread table, run queue, slice counter.
// Depends on rrts_pkg.
module rrts_dpath import rrts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  input  in_t         in_word,
  input  logic [15:0] slice_len,
  output sts_t        sts,
  output out_t        out_word
);

  logic [2:0]       tstat_r [NTHR];
  logic [ID_W-1:0]  q_r     [NTHR];
  logic [CNT_W-1:0] qcnt_r;
  logic [15:0]      slice_left_r;
  logic [ID_W-1:0]  search_r;
  logic [CNT_W-1:0] idx_r;
  logic [ID_W-1:0]  cur_r;
  logic [2:0]       mode_r;
  logic [ID_W-1:0]  id_r;
  logic [1:0]       status_r;
  logic [ID_W-1:0]  new_id_r;
  logic             sw_r;
  logic             fresh_r;

  logic [CNT_W-1:0] idx_p1;
  logic [ID_W-1:0]  taddr;
  logic [2:0]       tval;
  logic [ID_W-1:0]  qrd;
  logic [15:0]      slice_dec;

  assign idx_p1 = idx_r + CNT_W'(1);

  // single read port on the thread status table
  always_comb begin
    unique case (ctl.tsel)
      TSEL_SCAN: taddr = search_r + idx_r[ID_W-1:0];
      TSEL_HEAD: taddr = q_r[0];
      default:   taddr = id_r;
    endcase
  end
  assign tval      = tstat_r[taddr];
  assign qrd       = q_r[ctl.q_next ? idx_p1[ID_W-1:0] : idx_r[ID_W-1:0]];
  assign slice_dec = (slice_left_r != 16'd0) ? slice_left_r - 16'd1 : 16'd0;

  // status back to the sequencer
  assign sts.mode     = mode_r;
  assign sts.id_stat  = tval;
  assign sts.qcnt     = qcnt_r;
  assign sts.rot_go   = (qcnt_r > CNT_W'(1)) && (slice_dec == 16'd0);
  assign sts.idx_last = (idx_r == CNT_W'(NTHR - 1));
  assign sts.idx_end  = (idx_r >= qcnt_r);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.q_hit    = (qrd == id_r);
  assign sts.more     = (idx_p1 < qcnt_r);

  assign out_word.status         = status_r;
  assign out_word.new_id         = new_id_r;
  assign out_word.running_id     = q_r[0];
  assign out_word.switched       = sw_r;
  assign out_word.fresh_start    = fresh_r;
  assign out_word.runnable_count = qcnt_r;

  // table and queue updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // thread 0 starts out running, all others free
      for (int i = 0; i < NTHR; i++) begin
        tstat_r[i] <= (i == 0) ? TS_RUNNING : TS_FREE;
        q_r[i]     <= '0;
      end
      qcnt_r       <= CNT_W'(1);
      slice_left_r <= 16'd0;
      search_r     <= '0;
      idx_r        <= '0;
      cur_r        <= '0;
      mode_r       <= MODE_TICK;
      id_r         <= '0;
      status_r     <= STAT_OK;
      new_id_r     <= '0;
      sw_r         <= 1'b0;
      fresh_r      <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_LOAD: begin
          mode_r   <= in_word.mode;
          id_r     <= in_word.tid;
          status_r <= STAT_OK;
          new_id_r <= '0;
          sw_r     <= 1'b0;
          fresh_r  <= 1'b0;
          idx_r    <= '0;
        end
        OP_DEC: slice_left_r <= slice_dec;
        OP_ROT: begin
          cur_r         <= q_r[0];
          tstat_r[q_r[0]] <= TS_READY;
          idx_r         <= '0;
        end
        OP_SHIFT: begin
          q_r[idx_r[ID_W-1:0]] <= qrd;
          idx_r                <= idx_p1;
        end
        OP_TAIL: q_r[ID_W'(qcnt_r - CNT_W'(1))] <= cur_r;
        OP_DROP: qcnt_r <= qcnt_r - CNT_W'(1);
        OP_HEAD: begin
          slice_left_r <= slice_len;
          if (tval == TS_FRESH) begin
            tstat_r[taddr] <= TS_RUNNING;
            sw_r           <= 1'b1;
            fresh_r        <= 1'b1;
          end else if (tval == TS_READY) begin
            tstat_r[taddr] <= TS_RUNNING;
            sw_r           <= 1'b1;
          end
        end
        OP_INC: idx_r <= idx_p1;
        OP_CREATE: begin
          tstat_r[taddr] <= TS_CREATED;
          search_r       <= taddr;
          new_id_r       <= taddr;
        end
        OP_START: begin
          tstat_r[id_r]              <= TS_FRESH;
          q_r[qcnt_r[ID_W-1:0]]      <= id_r;
          qcnt_r                     <= qcnt_r + CNT_W'(1);
        end
        OP_END:  tstat_r[id_r] <= (mode_r == MODE_DESTROY) ? TS_FREE : TS_ENDED;
        OP_FREE: tstat_r[id_r] <= TS_FREE;
        OP_ERR:  status_r <= ctl.err;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler top: APB slice register, sequencer, datapath.
// Depends on rrts_pkg, rrts_ctrl, rrts_dpath and the assert macro header.
// One word at a time: start and destroy of an idle thread finish at decode, a create
// searches for a free id one entry a cycle, and a terminate, a destroy of a queued
// thread or a rotating tick walks the queue or rotates, shifts and reloads the head.
// The result strobe comes in the last cycle; the receiver cannot stall.
// Synchronous active-low reset: thread 0 running, queue holds id 0, slice 10.
`include "round_robin_thread_scheduler_assert.svh"
module round_robin_thread_scheduler import rrts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] slice_len_r;
  logic        accept;
  ctl_t        ctl;
  sts_t        sts;

  assign accept     = start && !busy;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_SLICE) ? {16'd0, slice_len_r} : 32'd0;

  // slice length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= 16'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_SLICE) begin
      slice_len_r <= cfg_pwdata[15:0];
    end
  end

  rrts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy),
    .done   (out_valid)
  );

  rrts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_word   (in_data),
    .slice_len (slice_len_r),
    .sts       (sts),
    .out_word  (out_data)
  );

  `RRTS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `RRTS_ASSERT_NEXT(a_accept_busy, accept, busy)
  `RRTS_ASSERT_IMPL(a_done_busy, out_valid, busy)
  `RRTS_ASSERT_IMPL(a_queue_nonempty, out_valid, out_data.runnable_count != 5'd0)

endmodule
